// ----- hw/rtl/hc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc_pkg
// Shared types, constants and the mod-26 fold used by the 2x2 hill cipher.
// ----------------------------------------------------------------------------
package hc_pkg;

  localparam int ALPHABET  = 26;
  localparam int LETTER_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * LETTER_W;

  // letter constants
  localparam logic [LETTER_W-1:0] PAD_LETTER  = LETTER_W'(23);
  localparam logic [LETTER_W-1:0] MOD_NEG_ONE = LETTER_W'(ALPHABET - 1);
  localparam logic [LETTER_W-1:0] SEARCH_LAST = LETTER_W'(ALPHABET - 1);
  localparam logic [LETTER_W-1:0] MOD_ONE     = LETTER_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_A   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = CFG_IDX_W'(4);

  // register reset values
  localparam logic [LETTER_W-1:0] KEY_A_RST = LETTER_W'(6);
  localparam logic [LETTER_W-1:0] KEY_B_RST = LETTER_W'(24);
  localparam logic [LETTER_W-1:0] KEY_C_RST = LETTER_W'(1);
  localparam logic [LETTER_W-1:0] KEY_D_RST = LETTER_W'(13);

  // key and mode as seen by the sequencer
  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic [LETTER_W-1:0] c;
    logic [LETTER_W-1:0] d;
    logic                decrypt;
  } key_cfg_t;

  // operands of the shared multiply-accumulate unit
  typedef struct packed {
    logic [LETTER_W-1:0] acc;
    logic [LETTER_W-1:0] x;
    logic [LETTER_W-1:0] y;
  } mac_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEG_B,
    ST_NEG_C,
    ST_DET_A,
    ST_DET_B,
    ST_SEARCH,
    ST_INV_0,
    ST_INV_1,
    ST_INV_2,
    ST_INV_3,
    ST_PAIR,
    ST_C0_A,
    ST_C0_B,
    ST_C1_A,
    ST_C1_B
  } seq_state_t;

  // reduce a 10-bit value mod 26: fold the upper bits twice with 32 = 6 mod 26,
  // then two conditional subtracts on a value below 74
  function automatic logic [LETTER_W-1:0] mod26_fold(input logic [PROD_W-1:0] v);
    logic [7:0] hi;
    logic [7:0] t;
    hi = {3'b000, v[PROD_W-1:LETTER_W]};
    t  = (hi << 2) + (hi << 1) + {3'b000, v[LETTER_W-1:0]};
    hi = {5'b00000, t[7:LETTER_W]};
    t  = (hi << 2) + (hi << 1) + {3'b000, t[LETTER_W-1:0]};
    for (int i = 0; i < 2; i++) begin
      if (t >= 8'(ALPHABET)) begin
        t = t - 8'(ALPHABET);
      end
    end
    return t[LETTER_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/hc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc_if
// Valid/ready channels of the hill cipher: letters in, letters out, config.
// ----------------------------------------------------------------------------
interface hc_in_if;
  logic                        valid;
  logic                        ready;
  logic [hc_pkg::LETTER_W-1:0] letter;
  logic                        last_letter;

  modport source (output valid, output letter, output last_letter, input ready);
  modport sink   (input valid, input letter, input last_letter, output ready);
endinterface

interface hc_out_if;
  logic                        valid;
  logic                        ready;
  logic [hc_pkg::LETTER_W-1:0] letter_out;
  logic                        last_out;
  logic                        key_error;

  modport source (output valid, output letter_out, output last_out, output key_error,
                  input ready);
  modport sink   (input valid, input letter_out, input last_out, input key_error,
                  output ready);
endinterface

interface hc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hc_pkg::CFG_IDX_W-1:0] index;
  logic [hc_pkg::LETTER_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/hill_cipher_2x2_mod26_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_top
// 2x2 hill cipher over letters 0..25 with an iterative mod-26 datapath.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    letter[4:0], last_letter
//  out_ch   out  valid/ready    letter_out[4:0], last_out, key_error
//  cfg_ch   in   valid/ready    index[2:0], data[4:0] (always ready)
//
//  A letter that opens a pair is only held; a letter that closes a pair
//  makes four passes through the shared mod-26 multiply-accumulate unit.
//  The first letter of a decrypt message adds four steps of determinant work,
//  an inverse search over 1 to 25 candidates (one candidate per cycle) and,
//  when an inverse exists, four steps for the adjugate, all on that same unit.
//  Reset is synchronous; nothing needs clearing afterwards.
//  One result waits in the output register; a full register stalls the
//  sequencer until out_ch takes it.
module hill_cipher_2x2_mod26_top (
  input  logic     clk,
  input  logic     rst_n,
  hc_in_if.sink    in_ch,
  hc_out_if.source out_ch,
  hc_cfg_if.sink   cfg_ch
);
  import hc_pkg::*;

  key_cfg_t            keys;
  mac_req_t            mac_req;
  logic [LETTER_W-1:0] mac_res;

  hc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .keys     (keys)
  );

  hc_mac_unit u_mac (
    .req (mac_req),
    .res (mac_res)
  );

  hc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_letter     (in_ch.letter),
    .in_last       (in_ch.last_letter),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_letter    (out_ch.letter_out),
    .out_last      (out_ch.last_out),
    .out_key_error (out_ch.key_error),
    .keys          (keys),
    .mac_req       (mac_req),
    .mac_res       (mac_res)
  );

endmodule

// ----- hw/rtl/hc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc_cfg_regs
// Key matrix and mode registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module hc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_valid,
  output logic                         wr_ready,
  input  logic [hc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [hc_pkg::LETTER_W-1:0]  wr_data,
  output hc_pkg::key_cfg_t             keys
);
  import hc_pkg::*;

  key_cfg_t keys_r;
  key_cfg_t keys_nxt;

  assign wr_ready = 1'b1;
  assign keys     = keys_r;

  // register decode, unknown indexes are dropped
  always_comb begin
    keys_nxt = keys_r;
    if (wr_valid) begin
      unique case (wr_index)
        REG_KEY_A:   keys_nxt.a       = wr_data;
        REG_KEY_B:   keys_nxt.b       = wr_data;
        REG_KEY_C:   keys_nxt.c       = wr_data;
        REG_KEY_D:   keys_nxt.d       = wr_data;
        REG_DECRYPT: keys_nxt.decrypt = wr_data[0];
        default:     keys_nxt         = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r.a       <= KEY_A_RST;
      keys_r.b       <= KEY_B_RST;
      keys_r.c       <= KEY_C_RST;
      keys_r.d       <= KEY_D_RST;
      keys_r.decrypt <= 1'b0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

endmodule

// ----- hw/rtl/hc_mac_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc_mac_unit
// Shared mod-26 multiply-accumulate: res = (acc + x * y) mod 26.
// ----------------------------------------------------------------------------
module hc_mac_unit (
  input  hc_pkg::mac_req_t              req,
  output logic [hc_pkg::LETTER_W-1:0]   res
);
  import hc_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;

  // 5x5 product plus accumulator, worst case 25 + 31 * 31 fits 10 bits
  assign prod = {{LETTER_W{1'b0}}, req.x} * {{LETTER_W{1'b0}}, req.y};
  assign sum  = prod + {{LETTER_W{1'b0}}, req.acc};
  assign res  = mod26_fold(sum);

endmodule

// ----- hw/rtl/hc_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc_seq
// Sequencer: prepares the active matrix per message, pairs letters and
// drives the shared mod-26 unit; holds one result in the output register.
// ----------------------------------------------------------------------------
module hc_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hc_pkg::LETTER_W-1:0] in_letter,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hc_pkg::LETTER_W-1:0] out_letter,
  output logic                        out_last,
  output logic                        out_key_error,
  input  hc_pkg::key_cfg_t            keys,
  output hc_pkg::mac_req_t            mac_req,
  input  logic [hc_pkg::LETTER_W-1:0] mac_res
);
  import hc_pkg::*;

  seq_state_t          state_r, state_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                last_r, last_nxt;
  logic [LETTER_W-1:0] held_r, held_nxt;
  logic                holding_r, holding_nxt;
  logic [LETTER_W-1:0] m_r [4];
  logic [LETTER_W-1:0] m_nxt [4];
  logic                mready_r, mready_nxt;
  logic                invalid_r, invalid_nxt;
  logic [LETTER_W-1:0] acc_r, acc_nxt;
  logic [LETTER_W-1:0] det_r, det_nxt;
  logic [LETTER_W-1:0] x_r, x_nxt;
  logic [LETTER_W-1:0] p0_r, p0_nxt;
  logic [LETTER_W-1:0] p1_r, p1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_letter_r, out_letter_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_err_r, out_err_nxt;

  logic in_fire;
  logic out_free;
  logic out_load;
  logic found;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign found         = (mac_res == MOD_ONE);
  assign out_valid     = out_valid_r;
  assign out_letter    = out_letter_r;
  assign out_last      = out_last_r;
  assign out_key_error = out_err_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (!mready_r && keys.decrypt) ? ST_NEG_B : ST_PAIR;
        end
      end
      ST_NEG_B:  state_nxt = ST_NEG_C;
      ST_NEG_C:  state_nxt = ST_DET_A;
      ST_DET_A:  state_nxt = ST_DET_B;
      ST_DET_B:  state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        priority if (found) begin
          state_nxt = ST_INV_0;
        end else if (x_r == SEARCH_LAST) begin
          state_nxt = ST_PAIR;
        end
      end
      ST_INV_0:  state_nxt = ST_INV_1;
      ST_INV_1:  state_nxt = ST_INV_2;
      ST_INV_2:  state_nxt = ST_INV_3;
      ST_INV_3:  state_nxt = ST_PAIR;
      ST_PAIR:   state_nxt = (!holding_r && !last_r) ? ST_IDLE : ST_C0_A;
      ST_C0_A:   state_nxt = ST_C0_B;
      ST_C0_B:   state_nxt = out_free ? ST_C1_A : ST_C0_B;
      ST_C1_A:   state_nxt = ST_C1_B;
      ST_C1_B:   state_nxt = out_free ? ST_IDLE : ST_C1_B;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // operands for the shared unit
  always_comb begin
    mac_req = '0;
    unique case (state_r)
      ST_NEG_B:  mac_req = '{acc: '0, x: keys.b, y: MOD_NEG_ONE};
      ST_NEG_C:  mac_req = '{acc: '0, x: keys.c, y: MOD_NEG_ONE};
      ST_DET_A:  mac_req = '{acc: '0, x: keys.a, y: keys.d};
      ST_DET_B:  mac_req = '{acc: acc_r, x: m_r[1], y: keys.c};
      ST_SEARCH: mac_req = '{acc: '0, x: det_r, y: x_r};
      ST_INV_0:  mac_req = '{acc: '0, x: keys.d, y: x_r};
      ST_INV_1:  mac_req = '{acc: '0, x: m_r[1], y: x_r};
      ST_INV_2:  mac_req = '{acc: '0, x: m_r[2], y: x_r};
      ST_INV_3:  mac_req = '{acc: '0, x: keys.a, y: x_r};
      ST_C0_A:   mac_req = '{acc: '0, x: m_r[0], y: p0_r};
      ST_C0_B:   mac_req = '{acc: acc_r, x: m_r[1], y: p1_r};
      ST_C1_A:   mac_req = '{acc: '0, x: m_r[2], y: p0_r};
      ST_C1_B:   mac_req = '{acc: acc_r, x: m_r[3], y: p1_r};
      default:   mac_req = '0;
    endcase
  end

  // datapath and register updates
  always_comb begin
    letter_nxt     = letter_r;
    last_nxt       = last_r;
    held_nxt       = held_r;
    holding_nxt    = holding_r;
    m_nxt          = m_r;
    mready_nxt     = mready_r;
    invalid_nxt    = invalid_r;
    acc_nxt        = acc_r;
    det_nxt        = det_r;
    x_nxt          = x_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    out_load       = 1'b0;
    out_letter_nxt = out_letter_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          letter_nxt = in_letter;
          last_nxt   = in_last;
          // encrypt takes the key as it stands
          if (!mready_r && !keys.decrypt) begin
            m_nxt[0]    = keys.a;
            m_nxt[1]    = keys.b;
            m_nxt[2]    = keys.c;
            m_nxt[3]    = keys.d;
            invalid_nxt = 1'b0;
            mready_nxt  = 1'b1;
          end
        end
      end
      ST_NEG_B: m_nxt[1] = mac_res;
      ST_NEG_C: m_nxt[2] = mac_res;
      ST_DET_A: acc_nxt  = mac_res;
      ST_DET_B: begin
        det_nxt = mac_res;
        x_nxt   = MOD_ONE;
      end
      ST_SEARCH: begin
        // x_r stays as the inverse once found
        priority if (found) begin
          x_nxt = x_r;
        end else if (x_r == SEARCH_LAST) begin
          m_nxt       = '{default: '0};
          invalid_nxt = 1'b1;
          mready_nxt  = 1'b1;
        end else begin
          x_nxt = x_r + MOD_ONE;
        end
      end
      ST_INV_0: m_nxt[0] = mac_res;
      ST_INV_1: m_nxt[1] = mac_res;
      ST_INV_2: m_nxt[2] = mac_res;
      ST_INV_3: begin
        m_nxt[3]    = mac_res;
        invalid_nxt = 1'b0;
        mready_nxt  = 1'b1;
      end
      ST_PAIR: begin
        if (!holding_r && !last_r) begin
          held_nxt    = letter_r;
          holding_nxt = 1'b1;
        end else begin
          // odd message end pads with 'x'
          p0_nxt      = holding_r ? held_r : letter_r;
          p1_nxt      = holding_r ? letter_r : PAD_LETTER;
          holding_nxt = 1'b0;
          held_nxt    = '0;
          if (last_r) begin
            mready_nxt = 1'b0;
          end
        end
      end
      ST_C0_A: acc_nxt = mac_res;
      ST_C0_B: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_letter_nxt = invalid_r ? '0 : mac_res;
          out_last_nxt   = 1'b0;
          out_err_nxt    = invalid_r;
        end
      end
      ST_C1_A: acc_nxt = mac_res;
      ST_C1_B: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_letter_nxt = invalid_r ? '0 : mac_res;
          out_last_nxt   = last_r;
          out_err_nxt    = invalid_r;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      holding_r   <= 1'b0;
      mready_r    <= 1'b0;
      invalid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      holding_r   <= holding_nxt;
      mready_r    <= mready_nxt;
      invalid_r   <= invalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    letter_r     <= letter_nxt;
    last_r       <= last_nxt;
    held_r       <= held_nxt;
    m_r          <= m_nxt;
    acc_r        <= acc_nxt;
    det_r        <= det_nxt;
    x_r          <= x_nxt;
    p0_r         <= p0_nxt;
    p1_r         <= p1_nxt;
    out_letter_r <= out_letter_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  // encrypt-mode key load is ready for the pair step that follows
  a_enc_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !mready_r && !keys.decrypt) |=> (mready_r && state_r == ST_PAIR))
    else $error("key matrix not loaded after message start");

  // inverse search stays within 1..25
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (x_r >= MOD_ONE && x_r <= SEARCH_LAST))
    else $error("inverse search index out of range");

  // a pair is never computed while a letter is still held
  a_pair_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_C0_A) |-> (!holding_r && $past(state_r) == ST_PAIR))
    else $error("pair computed with a letter still held");

  // the shared unit always reduces fully
  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res < LETTER_W'(ALPHABET))
    else $error("mod-26 result out of range");

endmodule
